@@ rtl/standard_deviation_block_core_assert.svh @@
// Assertion macros shared by the standard deviation block modules.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef STANDARD_DEVIATION_BLOCK_CORE_ASSERT_SVH
`define STANDARD_DEVIATION_BLOCK_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SDB_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SDB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/sdb_pkg.sv @@
// Package for the standard deviation block: widths, state and command types.
// Used by sdb_ctrl, sdb_datapath and standard_deviation_block_core; depends on nothing.
`timescale 1ns / 1ps

package sdb_pkg;

   // Block size and sample format.
   localparam int MAX_COUNT   = 4096;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 8;

   // Accumulator widths.
   localparam int COUNT_W = $clog2(MAX_COUNT + 1);
   localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_COUNT);
   localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
   localparam int S2_W    = SQ_W + $clog2(MAX_COUNT);

   // Shared multiplier; the sum of squares is multiplied in two halves.
   localparam int S2_LO_W = 22;
   localparam int S2_HI_W = S2_W - S2_LO_W;
   localparam int MUL_W   = SUM_W;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int ACC_W   = COUNT_W + S2_W;

   // Divider and square root.
   localparam int NUM_W  = ACC_W + 2 * FRAC_BITS;
   localparam int DIV_W  = 2 * COUNT_W;
   localparam int Q_W    = 48;
   localparam int ROOT_W = Q_W / 2;
   localparam int REM_W  = ROOT_W + 2;
   localparam int STEP_W = $clog2(NUM_W);

   // Port widths.
   localparam int REQ_DATA_W = SAMPLE_BITS;
   localparam int DEV_W      = 24;
   localparam int CNT_OUT_W  = 13;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [3:0] {
      ST_ACCUM,
      ST_DRAIN,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_MUL_SQ,
      ST_MUL_NN,
      ST_DIV_LOAD,
      ST_DIV_STEP,
      ST_SQRT_LOAD,
      ST_SQRT_STEP,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_MUL_LO,
      OP_MUL_HI,
      OP_MUL_SQ,
      OP_MUL_NN,
      OP_DIV_LOAD,
      OP_DIV_STEP,
      OP_SQRT_LOAD,
      OP_SQRT_STEP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      accept;
      logic      load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

@@ rtl/standard_deviation_block_core.sv @@
// Top level of the standard deviation block: controller plus datapath.
// Depends on sdb_pkg, sdb_ctrl and sdb_datapath.
`timescale 1ns / 1ps

// Streams signed 16-bit samples in, one word per clock, with req_tlast on the
// final sample of a block, and returns one result word per block: the population
// standard deviation in unsigned Q.8 (floored), the saturated sample count and an
// overflow flag set when the block held more than 4096 samples (only the first
// 4096 are then used). Samples are accepted every cycle while accumulating. After
// the final sample is accepted the block does not accept again until it has
// finished accumulating, run four products on the shared 28x28 multiplier,
// then a radix-2 restoring divider of 72 steps and a 24-step square root, each
// after a load step and each one bit or digit per cycle. The result appears on
// rsp_tvalid in the cycle after it is loaded into the output register, which
// holds it, so the next block can stream in while it waits to be taken. If the
// previous result word is still held when a new one is ready, the block stays in
// its last cycle, with req_tready low, until that word is taken.
module standard_deviation_block_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sdb_pkg::REQ_DATA_W-1:0]  req_tdata,  // [15:0] sample
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sdb_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // [23:0] std_dev_q8, [36:24] sample_count
   output logic                            rsp_tuser   // [0] overflow
);

   sdb_pkg::dp_cmd_type           cmd;
   sdb_pkg::dp_status_type        sts;
   logic [sdb_pkg::DEV_W-1:0]     std_dev;
   logic [sdb_pkg::CNT_OUT_W-1:0] count;

   sdb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sdb_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_sample   (req_tdata),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_std_dev  (std_dev),
      .rsp_count    (count),
      .rsp_overflow (rsp_tuser)
   );

   // Pack the result word, padded to whole bytes.
   assign rsp_tdata = {{(sdb_pkg::RSP_DATA_W - sdb_pkg::DEV_W - sdb_pkg::CNT_OUT_W){1'b0}},
                       count, std_dev};

endmodule

@@ rtl/sdb_ctrl.sv @@
// Controller for the standard deviation block: sequences accumulation, multiply,
// divide and square root steps. Depends on sdb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "standard_deviation_block_core_assert.svh"

module sdb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tlast,
   output logic                  req_tready,
   input  sdb_pkg::dp_status_type sts,
   output sdb_pkg::dp_cmd_type    cmd
);

   sdb_pkg::state_type             state_ff, state_in;
   logic [sdb_pkg::STEP_W-1:0]     cnt_ff, cnt_in;
   logic                           fire;

   assign req_tready = (state_ff == sdb_pkg::ST_ACCUM);
   assign fire       = req_tvalid && req_tready;

   // State and step counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdb_pkg::ST_ACCUM;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd.op       = sdb_pkg::OP_NONE;
      cmd.accept   = fire;
      cmd.load_out = 1'b0;
      case (state_ff)
         sdb_pkg::ST_ACCUM: begin
            if (fire && req_tlast) begin
               state_in = sdb_pkg::ST_DRAIN;
            end
         end
         sdb_pkg::ST_DRAIN: begin
            state_in = sdb_pkg::ST_MUL_LO;
         end
         sdb_pkg::ST_MUL_LO: begin
            cmd.op   = sdb_pkg::OP_MUL_LO;
            state_in = sdb_pkg::ST_MUL_HI;
         end
         sdb_pkg::ST_MUL_HI: begin
            cmd.op   = sdb_pkg::OP_MUL_HI;
            state_in = sdb_pkg::ST_MUL_SQ;
         end
         sdb_pkg::ST_MUL_SQ: begin
            cmd.op   = sdb_pkg::OP_MUL_SQ;
            state_in = sdb_pkg::ST_MUL_NN;
         end
         sdb_pkg::ST_MUL_NN: begin
            cmd.op   = sdb_pkg::OP_MUL_NN;
            state_in = sdb_pkg::ST_DIV_LOAD;
         end
         sdb_pkg::ST_DIV_LOAD: begin
            cmd.op   = sdb_pkg::OP_DIV_LOAD;
            cnt_in   = '0;
            state_in = sdb_pkg::ST_DIV_STEP;
         end
         sdb_pkg::ST_DIV_STEP: begin
            cmd.op = sdb_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == sdb_pkg::STEP_W'(sdb_pkg::NUM_W - 1)) begin
               state_in = sdb_pkg::ST_SQRT_LOAD;
            end
         end
         sdb_pkg::ST_SQRT_LOAD: begin
            cmd.op   = sdb_pkg::OP_SQRT_LOAD;
            cnt_in   = '0;
            state_in = sdb_pkg::ST_SQRT_STEP;
         end
         sdb_pkg::ST_SQRT_STEP: begin
            cmd.op = sdb_pkg::OP_SQRT_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == sdb_pkg::STEP_W'(sdb_pkg::ROOT_W - 1)) begin
               state_in = sdb_pkg::ST_FINISH;
            end
         end
         sdb_pkg::ST_FINISH: begin
            // Wait until the output register can take the result word.
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = sdb_pkg::ST_ACCUM;
            end
         end
         default: begin
            state_in = sdb_pkg::ST_ACCUM;
         end
      endcase
   end

   `SDB_ASSERT_NEXT(a_last_drains, fire && req_tlast, state_ff == sdb_pkg::ST_DRAIN, "final word did not start the computation")
   `SDB_ASSERT_NEXT(a_div_to_sqrt, state_ff == sdb_pkg::ST_DIV_STEP && cnt_ff == sdb_pkg::STEP_W'(sdb_pkg::NUM_W - 1), state_ff == sdb_pkg::ST_SQRT_LOAD, "divider ran the wrong number of steps")
   `SDB_ASSERT_NEXT(a_finish_returns, state_ff == sdb_pkg::ST_FINISH && sts.out_free, state_ff == sdb_pkg::ST_ACCUM && !req_tready == 1'b0, "block did not return to accumulation after the result")

endmodule

@@ rtl/sdb_datapath.sv @@
// Datapath for the standard deviation block: accumulators, shared multiplier,
// restoring divider, digit-by-digit square root and output register. Depends on sdb_pkg.
`timescale 1ns / 1ps
`include "standard_deviation_block_core_assert.svh"

module sdb_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  sdb_pkg::dp_cmd_type             cmd,
   output sdb_pkg::dp_status_type          sts,
   input  logic [sdb_pkg::REQ_DATA_W-1:0]  req_sample,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [sdb_pkg::DEV_W-1:0]       rsp_std_dev,
   output logic [sdb_pkg::CNT_OUT_W-1:0]   rsp_count,
   output logic                            rsp_overflow
);

   // Input stage.
   logic [sdb_pkg::SAMPLE_BITS-1:0] x_ff, x_in;
   logic [sdb_pkg::SQ_W-1:0]        sq_ff, sq_in;
   logic                            stage_vld_ff, stage_vld_in;
   logic signed [2*sdb_pkg::SAMPLE_BITS-1:0] sq_full;

   // Accumulators.
   logic [sdb_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [sdb_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [sdb_pkg::S2_W-1:0]    s2_ff, s2_in;
   logic                        ovf_ff, ovf_in;

   // Multiply, divide and square root.
   logic [sdb_pkg::MUL_W-1:0]   mul_a, mul_b, abs_sum;
   logic [sdb_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [sdb_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic [sdb_pkg::NUM_W-1:0]   num_ff, num_in;
   logic [sdb_pkg::DIV_W-1:0]   d_ff, d_in;
   logic [sdb_pkg::REM_W-1:0]   rem_ff, rem_in;
   logic [sdb_pkg::Q_W-1:0]     q_ff, q_in;
   logic [sdb_pkg::ROOT_W-1:0]  root_ff, root_in;
   logic [sdb_pkg::REM_W:0]     div_rem2, div_diff;
   logic [sdb_pkg::REM_W+1:0]   sq_rem2, sq_trial, sq_diff;

   // Output register.
   logic                          out_vld_ff, out_vld_in;
   logic [sdb_pkg::DEV_W-1:0]     out_dev_ff, out_dev_in;
   logic [sdb_pkg::CNT_OUT_W-1:0] out_cnt_ff, out_cnt_in;
   logic                          out_ovf_ff, out_ovf_in;

   assign sts.out_free = !out_vld_ff || rsp_tready;
   assign rsp_tvalid   = out_vld_ff;
   assign rsp_std_dev  = out_dev_ff;
   assign rsp_count    = out_cnt_ff;
   assign rsp_overflow = out_ovf_ff;

   // Square each accepted sample in the input stage.
   assign sq_full      = $signed(req_sample) * $signed(req_sample);
   assign x_in         = cmd.accept ? req_sample : x_ff;
   assign sq_in        = cmd.accept ? sq_full[sdb_pkg::SQ_W-1:0] : sq_ff;
   assign stage_vld_in = cmd.accept;

   // Count, sum and sum of squares; saturated blocks only set the overflow flag.
   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      s2_in    = s2_ff;
      ovf_in   = ovf_ff;
      if (cmd.load_out) begin
         count_in = '0;
         sum_in   = '0;
         s2_in    = '0;
         ovf_in   = 1'b0;
      end else if (stage_vld_ff) begin
         if (count_ff < sdb_pkg::COUNT_W'(sdb_pkg::MAX_COUNT)) begin
            count_in = count_ff + 1'b1;
            sum_in   = sum_ff + {{(sdb_pkg::SUM_W - sdb_pkg::SAMPLE_BITS){x_ff[sdb_pkg::SAMPLE_BITS-1]}},
                                 x_ff};
            s2_in    = s2_ff + sdb_pkg::S2_W'(sq_ff);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   // Shared multiplier operand selection.
   assign abs_sum = sum_ff[sdb_pkg::SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;

   always_comb begin
      mul_a = sdb_pkg::MUL_W'(count_ff);
      mul_b = sdb_pkg::MUL_W'(count_ff);
      case (cmd.op)
         sdb_pkg::OP_MUL_LO: mul_b = sdb_pkg::MUL_W'(s2_ff[sdb_pkg::S2_LO_W-1:0]);
         sdb_pkg::OP_MUL_HI: mul_b = sdb_pkg::MUL_W'(s2_ff[sdb_pkg::S2_W-1:sdb_pkg::S2_LO_W]);
         sdb_pkg::OP_MUL_SQ: begin
            mul_a = abs_sum;
            mul_b = abs_sum;
         end
         default: mul_b = sdb_pkg::MUL_W'(count_ff);
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Step helpers for the divider and the square root.
   assign div_rem2 = {rem_ff, num_ff[sdb_pkg::NUM_W-1]};
   assign div_diff = div_rem2 - (sdb_pkg::REM_W+1)'(d_ff);
   assign sq_rem2  = {rem_ff, q_ff[sdb_pkg::Q_W-1 -: 2]};
   assign sq_trial = {2'b00, root_ff, 2'b01};
   assign sq_diff  = sq_rem2 - sq_trial;

   // Variance numerator, then N*N, then division, then square root.
   always_comb begin
      acc_in  = acc_ff;
      num_in  = num_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      root_in = root_ff;
      case (cmd.op)
         sdb_pkg::OP_MUL_HI: acc_in = sdb_pkg::ACC_W'(prod_ff);
         sdb_pkg::OP_MUL_SQ: acc_in = acc_ff + sdb_pkg::ACC_W'(prod_ff << sdb_pkg::S2_LO_W);
         sdb_pkg::OP_MUL_NN: acc_in = acc_ff - sdb_pkg::ACC_W'(prod_ff);
         sdb_pkg::OP_DIV_LOAD: begin
            d_in   = prod_ff[sdb_pkg::DIV_W-1:0];
            num_in = {acc_ff, {(2*sdb_pkg::FRAC_BITS){1'b0}}};
            rem_in = '0;
            q_in   = '0;
         end
         sdb_pkg::OP_DIV_STEP: begin
            num_in = {num_ff[sdb_pkg::NUM_W-2:0], 1'b0};
            if (div_rem2 >= (sdb_pkg::REM_W+1)'(d_ff)) begin
               rem_in = div_diff[sdb_pkg::REM_W-1:0];
               q_in   = {q_ff[sdb_pkg::Q_W-2:0], 1'b1};
            end else begin
               rem_in = div_rem2[sdb_pkg::REM_W-1:0];
               q_in   = {q_ff[sdb_pkg::Q_W-2:0], 1'b0};
            end
         end
         sdb_pkg::OP_SQRT_LOAD: begin
            rem_in  = '0;
            root_in = '0;
         end
         sdb_pkg::OP_SQRT_STEP: begin
            q_in = {q_ff[sdb_pkg::Q_W-3:0], 2'b00};
            if (sq_rem2 >= sq_trial) begin
               rem_in  = sq_diff[sdb_pkg::REM_W-1:0];
               root_in = {root_ff[sdb_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = sq_rem2[sdb_pkg::REM_W-1:0];
               root_in = {root_ff[sdb_pkg::ROOT_W-2:0], 1'b0};
            end
         end
         default: acc_in = acc_ff;
      endcase
   end

   // Output register holds a finished word until it is taken.
   always_comb begin
      out_vld_in = out_vld_ff;
      out_dev_in = out_dev_ff;
      out_cnt_in = out_cnt_ff;
      out_ovf_in = out_ovf_ff;
      if (cmd.load_out) begin
         out_vld_in = 1'b1;
         out_dev_in = root_ff;
         out_cnt_in = sdb_pkg::CNT_OUT_W'(count_ff);
         out_ovf_in = ovf_ff;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
         count_ff     <= '0;
         sum_ff       <= '0;
         s2_ff        <= '0;
         ovf_ff       <= 1'b0;
         out_vld_ff   <= 1'b0;
      end else begin
         stage_vld_ff <= stage_vld_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         s2_ff        <= s2_in;
         ovf_ff       <= ovf_in;
         out_vld_ff   <= out_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      sq_ff      <= sq_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      num_ff     <= num_in;
      d_ff       <= d_in;
      rem_ff     <= rem_in;
      q_ff       <= q_in;
      root_ff    <= root_in;
      out_dev_ff <= out_dev_in;
      out_cnt_ff <= out_cnt_in;
      out_ovf_ff <= out_ovf_in;
   end

   `SDB_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= sdb_pkg::COUNT_W'(sdb_pkg::MAX_COUNT), "sample count exceeded its maximum")
   `SDB_ASSERT_SAME(a_div_rem_bound, cmd.op == sdb_pkg::OP_DIV_STEP, (sdb_pkg::DIV_W+1)'(rem_ff) < (sdb_pkg::DIV_W+1)'(d_ff), "divider remainder not below divisor")
   `SDB_ASSERT_SAME(a_quot_range, cmd.op == sdb_pkg::OP_SQRT_LOAD, q_ff[sdb_pkg::Q_W-1] == 1'b0, "scaled variance out of range")

endmodule
